@@ rtl/core/tcce_pkg.sv @@
// Shared constants for the text console cell engine: command codes,
// configuration register indexes, reset values and character codes.
// No dependencies.
`default_nettype none

package tcce_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] CMD_PUT    = 3'd0;
  localparam logic [2:0] CMD_SCROLL = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_HOME   = 3'd3;
  localparam logic [2:0] CMD_HLINE  = 3'd4;
  localparam logic [2:0] CMD_VLINE  = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 2'd3;

  localparam logic [7:0] RESET_WIDTH  = 8'd80;
  localparam logic [6:0] RESET_HEIGHT = 7'd25;

  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP = 8;

endpackage

`default_nettype wire

@@ rtl/core/text_console_cell_engine_core.sv @@
// Text console cell engine: cell store, cursor, command sequencer.
// Depends on tcce_pkg (command codes, register indexes, constants).
//
// Usage:
//  - Configuration: cfg_we with cfg_index/cfg_data writes one of width, height,
//    upper and lower limit per clock edge. Write only while busy is low.
//  - Commands: an item is taken at a clock edge with start high and busy low.
//    busy stays high until the result has been formed.
//  - Results: done is high for one cycle with cursor_col, cursor_row and
//    cell_data; the receiver cannot stall, so results are never held.
//  - Sequencing: every cell access runs through one multiplier for the start and
//    end address (S_MUL0, then S_MUL1) and one shared address adder that walks
//    the store one cell per cycle, or through S_SRC and S_WR per cell on a scroll.
//    Commands that touch no cell go from S_DEC straight to S_FIN. A read passes
//    S_DEC, S_MUL0, S_MUL1, S_RD, S_FIN; put, line, clear and scroll pass S_DEC,
//    S_MUL0, S_MUL1, the walk through the store, then S_FIN.
//    One item at a time; the next item is taken in the cycle done is shown.
//  - Reset: rst (synchronous) restores the registers, homes the cursor and
//    starts a clearing pass that writes blank to all MAX_COLS*MAX_ROWS cells,
//    one per cycle; busy is high meanwhile.
`default_nettype none

module text_console_cell_engine_core #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      cmd,
  input  logic [7:0]                      ch,
  input  logic [3:0]                      fore,
  input  logic [3:0]                      back,
  input  logic [5:0]                      row,
  input  logic [6:0]                      col,
  input  logic [6:0]                      end_pos,
  output logic                            done,
  output logic [6:0]                      cursor_col,
  output logic [6:0]                      cursor_row,
  output logic [15:0]                     cell_data
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int AW1 = AW + 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int YW  = $clog2(MAX_ROWS + 1);
  localparam int XW  = $clog2(MAX_COLS);
  localparam int XT  = CW + 1;
  localparam int PW  = CW + YW + 1;
  localparam int LW0 = (CW > YW) ? CW : YW;
  localparam int LW  = (LW0 > 7) ? LW0 : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL0, S_MUL1, S_SRC, S_WR, S_RD, S_FIN
  } state_t;

  typedef enum logic [1:0] {M_FILL, M_SCROLL, M_READ} mode_t;

  // configuration registers
  logic [7:0] screen_width;
  logic [6:0] screen_height;
  logic [5:0] upper_limit;
  logic [5:0] lower_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= tcce_pkg::RESET_WIDTH;
      screen_height <= tcce_pkg::RESET_HEIGHT;
      upper_limit   <= '0;
      lower_limit   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcce_pkg::REG_WIDTH:  screen_width  <= cfg_data;
        tcce_pkg::REG_HEIGHT: screen_height <= cfg_data[6:0];
        tcce_pkg::REG_UPPER:  upper_limit   <= cfg_data[5:0];
        tcce_pkg::REG_LOWER:  lower_limit   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] ew;
  logic [YW-1:0] eh, eup, elow, bottom;

  always_comb begin
    if (screen_width == '0)
      ew = CW'(1);
    else if (32'(screen_width) > MAX_COLS)
      ew = CW'(MAX_COLS);
    else
      ew = CW'(screen_width);

    if (screen_height == '0)
      eh = YW'(1);
    else if (32'(screen_height) > MAX_ROWS)
      eh = YW'(MAX_ROWS);
    else
      eh = YW'(screen_height);

    if (LW'(upper_limit) >= LW'(eh))
      eup = eh - YW'(1);
    else
      eup = YW'(upper_limit);

    if (LW'(lower_limit) >= LW'(eh))
      elow = eh - YW'(1);
    else
      elow = YW'(lower_limit);

    bottom = eh - elow - YW'(1);
  end

  state_t          state;
  mode_t           mode;
  logic            init;
  logic [XW-1:0]   cur_x;
  logic [YW-1:0]   cur_y;
  logic [2:0]      l_cmd;
  logic [7:0]      l_ch;
  logic [7:0]      l_attr;
  logic [5:0]      l_row;
  logic [6:0]      l_col;
  logic [6:0]      l_end;
  logic [YW-1:0]   r0, r1;
  logic [CW-1:0]   c0, c1;
  logic [AW1-1:0]  addr, last;
  logic [15:0]     value;
  logic            stepw;
  logic            copy_sel;

  // put char: new cursor and target cell
  logic [XT-1:0] px, wx, tab;
  logic [YW-1:0] py, wy;
  logic          pwr, p_go;
  logic [15:0]   pval;

  always_comb begin
    px   = XT'(cur_x);
    py   = cur_y;
    wx   = XT'(cur_x);
    wy   = cur_y;
    pwr  = 1'b0;
    pval = {l_attr, l_ch};
    tab  = (XT'(cur_x) + XT'(tcce_pkg::TAB_STOP)) & ~XT'(tcce_pkg::TAB_STOP - 1);
    case (l_ch)
      tcce_pkg::CH_BS: begin
        if (cur_x != '0) begin
          px = XT'(cur_x) - XT'(1);
        end else if (cur_y != '0) begin
          px = XT'(ew) - XT'(1);
          py = cur_y - YW'(1);
        end
        wx   = px;
        wy   = py;
        pwr  = 1'b1;
        pval = {l_attr, tcce_pkg::CH_SPACE};
      end
      tcce_pkg::CH_TAB: begin
        if (tab < XT'(ew)) px = tab;
      end
      tcce_pkg::CH_CR: begin
        px = '0;
      end
      tcce_pkg::CH_LF: begin
        px = '0;
        py = (cur_y < eh) ? cur_y + YW'(1) : eh;
      end
      default: begin
        if (!l_ch[7] && l_ch >= tcce_pkg::CH_SPACE) begin
          pwr = 1'b1;
          px  = XT'(cur_x) + XT'(1);
        end
      end
    endcase
    // wrap to the next row
    if (px >= XT'(ew)) begin
      px = '0;
      py = (py < eh) ? py + YW'(1) : eh;
    end
    p_go = pwr && (wy < eh) && (wx < XT'(ew));
  end

  // lines, scroll and read decode
  logic [LW-1:0] ha, hb, hr, va, vb, vc;
  logic          h_go, v_go, s_go, rd_ok;
  logic [YW-1:0] s_start;

  always_comb begin
    ha = (l_col > l_end) ? LW'(l_end) : LW'(l_col);
    hb = (l_col > l_end) ? LW'(l_col) : LW'(l_end);
    if (hb >= LW'(ew)) hb = LW'(ew) - LW'(1);
    hr = (LW'(l_row) >= LW'(eh)) ? LW'(eh) - LW'(1) : LW'(l_row);
    h_go = (ha <= hb);

    va = (LW'(l_row) > LW'(l_end)) ? LW'(l_end) : LW'(l_row);
    vb = (LW'(l_row) > LW'(l_end)) ? LW'(l_row) : LW'(l_end);
    if (vb >= LW'(eh)) vb = LW'(eh) - LW'(1);
    vc = (LW'(l_col) >= LW'(ew)) ? LW'(ew) - LW'(1) : LW'(l_col);
    v_go = (va <= vb);

    s_go    = (cur_y >= (eh - elow));
    s_start = (eup < bottom) ? eup : bottom;

    rd_ok = (LW'(l_row) < LW'(eh)) && (LW'(l_col) < LW'(ew));
  end

  // shared multiplier: row * width + column, one product per cycle
  logic [YW-1:0] mrow;
  logic [CW-1:0] mcol;
  logic [PW-1:0] prod;

  assign mrow = (state == S_MUL1) ? r1 : r0;
  assign mcol = (state == S_MUL1) ? c1 : c0;
  assign prod = PW'(mrow) * PW'(ew) + PW'(mcol);

  // shared address adder: next cell, next row, or scroll source
  logic [AW1-1:0] addend, sum;

  assign addend = ((state == S_SRC) || stepw) ? AW1'(ew) : AW1'(1);
  assign sum    = addr + addend;

  // cell store
  logic [15:0]   cell_mem [CELL_COUNT];
  logic [15:0]   rd_q;
  logic [15:0]   wdata;
  logic          mem_we;
  logic [AW-1:0] raddr;

  assign mem_we = (state == S_WR) && !rst;
  assign wdata  = copy_sel ? rd_q : value;
  assign raddr  = (state == S_SRC) ? sum[AW-1:0] : addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[addr[AW-1:0]] <= wdata;
    rd_q <= cell_mem[raddr];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WR;
      init       <= 1'b1;
      mode       <= M_FILL;
      addr       <= '0;
      last       <= AW1'(CELL_COUNT);
      value      <= tcce_pkg::BLANK_CELL;
      stepw      <= 1'b0;
      copy_sel   <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      done       <= 1'b0;
      cursor_col <= '0;
      cursor_row <= '0;
      cell_data  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            l_cmd  <= cmd;
            l_ch   <= ch;
            l_attr <= {back, fore};
            l_row  <= row;
            l_col  <= col;
            l_end  <= end_pos;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_FIN;
          mode  <= M_FILL;
          stepw <= 1'b0;
          case (l_cmd)
            tcce_pkg::CMD_PUT: begin
              cur_x <= XW'(px);
              cur_y <= py;
              if (p_go) begin
                r0    <= wy;
                c0    <= CW'(wx);
                r1    <= wy;
                c1    <= CW'(wx + XT'(1));
                value <= pval;
                state <= S_MUL0;
              end
            end
            tcce_pkg::CMD_SCROLL: begin
              if (s_go) begin
                cur_y <= bottom;
                r0    <= s_start;
                c0    <= '0;
                r1    <= bottom + YW'(1);
                c1    <= '0;
                value <= tcce_pkg::BLANK_CELL;
                mode  <= M_SCROLL;
                state <= S_MUL0;
              end
            end
            tcce_pkg::CMD_CLEAR, tcce_pkg::CMD_HOME: begin
              r0    <= '0;
              c0    <= '0;
              r1    <= eh;
              c1    <= '0;
              value <= tcce_pkg::BLANK_CELL;
              state <= S_MUL0;
              if (l_cmd == tcce_pkg::CMD_HOME) begin
                cur_x <= '0;
                cur_y <= eup;
              end
            end
            tcce_pkg::CMD_HLINE: begin
              if (h_go) begin
                r0    <= YW'(hr);
                c0    <= CW'(ha);
                r1    <= YW'(hr);
                c1    <= CW'(hb + LW'(1));
                value <= {l_attr, l_ch};
                state <= S_MUL0;
              end
            end
            tcce_pkg::CMD_VLINE: begin
              if (v_go) begin
                r0    <= YW'(va);
                c0    <= CW'(vc);
                r1    <= YW'(vb + LW'(1));
                c1    <= CW'(vc);
                value <= {l_attr, l_ch};
                stepw <= 1'b1;
                state <= S_MUL0;
              end
            end
            tcce_pkg::CMD_READ: begin
              if (rd_ok) begin
                r0    <= YW'(l_row);
                c0    <= CW'(l_col);
                r1    <= YW'(l_row);
                c1    <= CW'(l_col);
                mode  <= M_READ;
                state <= S_MUL0;
              end
            end
            default: ;
          endcase
        end
        S_MUL0: begin
          addr  <= prod[AW1-1:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          last     <= prod[AW1-1:0];
          copy_sel <= 1'b0;
          case (mode)
            M_READ:   state <= S_RD;
            M_SCROLL: state <= S_SRC;
            default:  state <= S_WR;
          endcase
        end
        S_SRC: begin
          // copy from the row below while it is inside the region, else blank
          copy_sel <= (sum < last);
          state    <= S_WR;
        end
        S_WR: begin
          addr     <= sum;
          copy_sel <= 1'b0;
          if (sum == last) begin
            if (init) begin
              init  <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_FIN;
            end
          end else if (mode == M_SCROLL) begin
            state <= S_SRC;
          end
        end
        S_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          done       <= 1'b1;
          cursor_col <= 7'(cur_x);
          cursor_row <= 7'(cur_y);
          cell_data  <= (mode == M_READ) ? rd_q : '0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tcce_check.sv @@
// Port-level checks for text_console_cell_engine_core, bound into that module.
// Depends on text_console_cell_engine_core ports only.
`default_nettype none

module tcce_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [6:0]  cursor_col,
  input logic [6:0]  cursor_row,
  input logic [15:0] cell_data
);

  // a result only shows once the engine has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // result ports hold while a command is in progress
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy) && !$past(rst)) |->
      ($stable(cursor_col) && $stable(cursor_row) && $stable(cell_data)))
    else $error("result ports changed while busy");

endmodule

bind text_console_cell_engine_core tcce_check u_tcce_check (.*);

`default_nettype wire
